// ----- rtl/core/psf_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, item type and constants of the spring force block.
package psf_pkg;

    localparam int IN_W  = 32;          // position and force width
    localparam int CFG_W = 31;          // k, L and inverse mass width
    localparam int AX_W  = 33;          // |p - o| per axis
    localparam int SQ_W  = 2 * AX_W;    // sum of squares
    localparam int LEN_W = AX_W;        // floor(sqrt(S))
    localparam int KM_W  = CFG_W + LEN_W;
    localparam int HALF_W = 32;         // split point of k*m for the axis multiply
    localparam int PP_W  = HALF_W + AX_W;
    localparam int NUM_W = KM_W + AX_W; // k*m*|d|
    localparam int Q_W   = 32;          // quotient bits kept before saturation
    localparam int LANES = 3;

    localparam logic [IN_W-1:0] F_MAX  = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] F_MIN  = 32'h8000_0000;
    localparam logic [IN_W-1:0] F_ZERO = 32'h0000_0000;

    localparam logic [CFG_W-1:0] K_RESET = 31'd65536;
    localparam logic [CFG_W-1:0] L_RESET = 31'd65536;

    typedef enum logic {
        REG_K = 1'b0,
        REG_L = 1'b1
    } t_reg_idx;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [AX_W-1:0] ax;
        logic [AX_W-1:0] ay;
        logic [AX_W-1:0] az;
        logic [2:0]      pos;    // axis difference strictly positive (z, y, x)
        logic            nofrc;  // immovable or zero distance
    } t_item;

endpackage

// ----- rtl/core/psf_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: particle and anchor positions plus inverse mass.
interface psf_in_if;
    import psf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  pos_x;
    logic signed [IN_W-1:0]  pos_y;
    logic signed [IN_W-1:0]  pos_z;
    logic signed [IN_W-1:0]  anchor_x;
    logic signed [IN_W-1:0]  anchor_y;
    logic signed [IN_W-1:0]  anchor_z;
    logic [CFG_W-1:0]        inverse_mass;

    modport source(output valid, pos_x, pos_y, pos_z, anchor_x, anchor_y, anchor_z,
                   inverse_mass, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, anchor_x, anchor_y, anchor_z,
                 inverse_mass, output ready);
endinterface

// ----- rtl/core/psf_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: saturated spring force and its valid flag.
interface psf_out_if;
    import psf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  force_x;
    logic signed [IN_W-1:0]  force_y;
    logic signed [IN_W-1:0]  force_z;
    logic                    force_valid;

    modport source(output valid, force_x, force_y, force_z, force_valid, input ready);
    modport sink(input valid, force_x, force_y, force_z, force_valid, output ready);
endinterface

// ----- rtl/core/psf_front.sv -----
`timescale 1ns / 1ps
// Front stage: takes input transfers, forms |d| per axis and flags no-force items.
module psf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psf_in_if.sink          i_in,
    output logic            o_valid,
    output psf_pkg::t_item  o_item,
    input  logic            i_ready
);
    import psf_pkg::*;

    logic  r_fv;
    t_item r_item;
    t_item n_item;
    logic  adv;
    logic [AX_W-1:0] dx, dy, dz;

    function automatic logic [AX_W-1:0] diff(input logic [IN_W-1:0] p,
                                             input logic [IN_W-1:0] o);
        diff = {p[IN_W-1], p} - {o[IN_W-1], o};
    endfunction

    function automatic logic [AX_W-1:0] mag(input logic [AX_W-1:0] d);
        mag = d[AX_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign dx = diff(i_in.pos_x, i_in.anchor_x);
    assign dy = diff(i_in.pos_y, i_in.anchor_y);
    assign dz = diff(i_in.pos_z, i_in.anchor_z);

    always_comb begin
        n_item.ax    = mag(dx);
        n_item.ay    = mag(dy);
        n_item.az    = mag(dz);
        n_item.pos   = {!dz[AX_W-1] && (dz != '0),
                        !dy[AX_W-1] && (dy != '0),
                        !dx[AX_W-1] && (dx != '0)};
        n_item.nofrc = (i_in.inverse_mass == '0) || ((dx | dy | dz) == '0);
    end

    assign adv        = !r_fv || i_ready;
    assign i_in.ready = adv;
    assign o_valid    = r_fv;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (adv) begin
            r_fv <= i_in.valid;
        end
        if (adv && i_in.valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/core/psf_fifo.sv -----
`timescale 1ns / 1ps
// Short queue between front and back.
module psf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_v,
    output logic            o_push_rdy,
    input  psf_pkg::t_item  i_push_item,
    output logic            o_pop_v,
    input  logic            i_pop,
    output psf_pkg::t_item  o_pop_item
);
    import psf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_push_rdy = r_count != CW'(DEPTH);
    assign o_pop_v    = r_count != '0;
    assign push       = i_push_v && o_push_rdy;
    assign pop        = i_pop && o_pop_v;
    assign o_pop_item = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != CW'(DEPTH)) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/psf_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with sideband.
module psf_sqrt #(
    parameter int SB_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_v,
    input  logic [psf_pkg::SQ_W-1:0]    i_s,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_v,
    output logic [psf_pkg::LEN_W-1:0]   o_root,
    output logic [SB_W-1:0]             o_sb
);
    import psf_pkg::*;

    localparam int REM_W = LEN_W + 2;

    logic               r_v    [LEN_W];
    logic [REM_W-1:0]   r_rem  [LEN_W];
    logic [LEN_W-1:0]   r_root [LEN_W];
    logic [SQ_W-1:0]    r_s    [LEN_W];
    logic [SB_W-1:0]    r_sb   [LEN_W];

    genvar j;
    generate
        for (j = 0; j < LEN_W; j++) begin : g_stage
            logic               v_in;
            logic [REM_W-1:0]   rem_in;
            logic [LEN_W-1:0]   root_in;
            logic [SQ_W-1:0]    s_in;
            logic [SB_W-1:0]    sb_in;
            logic [REM_W-1:0]   rem_t;
            logic [REM_W-1:0]   trial;
            logic               ge;

            if (j == 0) begin : g_first
                assign v_in    = i_v;
                assign rem_in  = '0;
                assign root_in = '0;
                assign s_in    = i_s;
                assign sb_in   = i_sb;
            end else begin : g_next
                assign v_in    = r_v[j-1];
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
                assign s_in    = r_s[j-1];
                assign sb_in   = r_sb[j-1];
            end

            assign rem_t = {rem_in[REM_W-3:0], s_in[SQ_W-1 -: 2]};
            assign trial = {root_in, 2'b01};
            assign ge    = rem_t >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= v_in;
                end
                if (i_en) begin
                    r_rem[j]  <= ge ? (rem_t - trial) : rem_t;
                    r_root[j] <= {root_in[LEN_W-2:0], ge};
                    r_s[j]    <= s_in << 2;
                    r_sb[j]   <= sb_in;
                end
            end
        end
    endgenerate

    assign o_v    = r_v[LEN_W-1];
    assign o_root = r_root[LEN_W-1];
    assign o_sb   = r_sb[LEN_W-1];

endmodule

// ----- rtl/core/psf_div.sv -----
`timescale 1ns / 1ps
// Pipelined three-lane restoring divider: 32 quotient bits plus overflow flag.
module psf_div #(
    parameter int DEN_W = 49,
    parameter int SB_W  = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_v,
    input  logic [psf_pkg::NUM_W-1:0]   i_num [psf_pkg::LANES],
    input  logic [DEN_W-1:0]            i_den,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_v,
    output logic [psf_pkg::Q_W-1:0]     o_q   [psf_pkg::LANES],
    output logic [psf_pkg::LANES-1:0]   o_ovf,
    output logic [SB_W-1:0]             o_sb
);
    import psf_pkg::*;

    localparam int HI_W = NUM_W - Q_W;
    localparam int NS   = Q_W + 1;

    logic               r_v   [NS];
    logic [DEN_W-1:0]   r_den [NS];
    logic [SB_W-1:0]    r_sb  [NS];
    logic [LANES-1:0]   r_ovf [NS];
    logic [DEN_W-1:0]   r_rem [NS][LANES];
    logic [Q_W-1:0]     r_lo  [NS][LANES];
    logic [Q_W-1:0]     r_q   [NS][LANES];

    // Stage 0: overflow test (quotient would reach 2^32) and remainder seed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
        end
        if (i_en) begin
            r_den[0] <= i_den;
            r_sb[0]  <= i_sb;
            for (int l = 0; l < LANES; l++) begin
                r_ovf[0][l] <= i_num[l][NUM_W-1:Q_W] >= HI_W'(i_den);
                r_rem[0][l] <= i_num[l][Q_W +: DEN_W];
                r_lo[0][l]  <= i_num[l][Q_W-1:0];
                r_q[0][l]   <= '0;
            end
        end
    end

    genvar j, k;
    generate
        for (j = 1; j < NS; j++) begin : g_stage
            for (k = 0; k < LANES; k++) begin : g_lane
                logic [DEN_W:0] rem_t;
                logic           ge;

                assign rem_t = {r_rem[j-1][k], r_lo[j-1][k][Q_W-1]};
                assign ge    = rem_t >= {1'b0, r_den[j-1]};

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[j][k] <= ge ? DEN_W'(rem_t - {1'b0, r_den[j-1]})
                                          : DEN_W'(rem_t);
                        r_lo[j][k]  <= r_lo[j-1][k] << 1;
                        r_q[j][k]   <= {r_q[j-1][k][Q_W-2:0], ge};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= r_v[j-1];
                end
                if (i_en) begin
                    r_den[j] <= r_den[j-1];
                    r_sb[j]  <= r_sb[j-1];
                    r_ovf[j] <= r_ovf[j-1];
                end
            end
        end
    endgenerate

    assign o_v   = r_v[NS-1];
    assign o_q   = r_q[NS-1];
    assign o_ovf = r_ovf[NS-1];
    assign o_sb  = r_sb[NS-1];

endmodule

// ----- rtl/core/psf_back.sv -----
`timescale 1ns / 1ps
// Back pipeline: |d|, spring stretch, k*m*|d_i| / (|d| * 2^F) and saturation.
module psf_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_v,
    output logic                        o_pop,
    input  psf_pkg::t_item              i_item,
    input  logic [psf_pkg::CFG_W-1:0]   i_k,
    input  logic [psf_pkg::CFG_W-1:0]   i_l,
    psf_out_if.source                   o_out
);
    import psf_pkg::*;

    localparam int DEN_W  = LEN_W + FRAC_BITS;
    localparam int ITEM_W = $bits(t_item);
    localparam int DSB_W  = 4;

    logic en;

    logic              r1_v;
    t_item             r1_item;
    logic [SQ_W-1:0]   r1_sq [LANES];
    logic              r2_v;
    t_item             r2_item;
    logic [SQ_W-1:0]   r2_s;

    logic              sq_v;
    logic [LEN_W-1:0]  sq_root;
    t_item             sq_item;

    logic              r3_v;
    t_item             r3_item;
    logic [LEN_W-1:0]  r3_m;
    logic [DEN_W-1:0]  r3_den;
    logic              r4_v;
    t_item             r4_item;
    logic [KM_W-1:0]   r4_km;
    logic [DEN_W-1:0]  r4_den;
    logic              r5_v;
    t_item             r5_item;
    logic [PP_W-1:0]   r5_pl [LANES];
    logic [PP_W-1:0]   r5_ph [LANES];
    logic [DEN_W-1:0]  r5_den;
    logic              r6_v;
    t_item             r6_item;
    logic [NUM_W-1:0]  r6_num [LANES];
    logic [DEN_W-1:0]  r6_den;

    logic              dv_v;
    logic [Q_W-1:0]    dv_q [LANES];
    logic [LANES-1:0]  dv_ovf;
    logic [DSB_W-1:0]  dv_sb;

    logic              r_ov;
    logic [IN_W-1:0]   r_f [LANES];
    logic              r_fvalid;
    logic [IN_W-1:0]   n_f [LANES];
    logic [AX_W-1:0]   ax_l [LANES];
    logic [LEN_W-1:0]  len_l;

    // whole back pipeline moves together; output register frees on transfer
    assign en    = !r_ov || o_out.ready;
    assign o_pop = en;

    assign ax_l[0] = r4_item.ax;
    assign ax_l[1] = r4_item.ay;
    assign ax_l[2] = r4_item.az;
    assign len_l   = LEN_W'(i_l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_v;
            r2_v <= r1_v;
            r3_v <= sq_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
        if (en) begin
            r1_item  <= i_item;
            r1_sq[0] <= SQ_W'(i_item.ax) * SQ_W'(i_item.ax);
            r1_sq[1] <= SQ_W'(i_item.ay) * SQ_W'(i_item.ay);
            r1_sq[2] <= SQ_W'(i_item.az) * SQ_W'(i_item.az);
            r2_item  <= r1_item;
            r2_s     <= r1_sq[0] + r1_sq[1] + r1_sq[2];

            r3_item  <= sq_item;
            r3_m     <= (sq_root >= len_l) ? (sq_root - len_l) : (len_l - sq_root);
            r3_den   <= DEN_W'(sq_root) << FRAC_BITS;

            r4_item  <= r3_item;
            r4_km    <= KM_W'(i_k) * KM_W'(r3_m);
            r4_den   <= r3_den;

            r5_item  <= r4_item;
            r5_den   <= r4_den;
            for (int l = 0; l < LANES; l++) begin
                r5_pl[l] <= PP_W'(r4_km[HALF_W-1:0]) * PP_W'(ax_l[l]);
                r5_ph[l] <= PP_W'(r4_km[KM_W-1:HALF_W]) * PP_W'(ax_l[l]);
            end

            r6_item  <= r5_item;
            r6_den   <= r5_den;
            for (int l = 0; l < LANES; l++) begin
                r6_num[l] <= NUM_W'(r5_pl[l]) + (NUM_W'(r5_ph[l]) << HALF_W);
            end
        end
    end

    logic [ITEM_W-1:0] sq_sb;

    psf_sqrt #(
        .SB_W(ITEM_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (r2_v),
        .i_s    (r2_s),
        .i_sb   (r2_item),
        .o_v    (sq_v),
        .o_root (sq_root),
        .o_sb   (sq_sb)
    );
    assign sq_item = t_item'(sq_sb);

    psf_div #(
        .DEN_W(DEN_W),
        .SB_W (DSB_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_v    (r6_v),
        .i_num  (r6_num),
        .i_den  (r6_den),
        .i_sb   ({r6_item.pos, r6_item.nofrc}),
        .o_v    (dv_v),
        .o_q    (dv_q),
        .o_ovf  (dv_ovf),
        .o_sb   (dv_sb)
    );

    // sign and saturation; no-force items get zero, pos lanes get -q, others +q
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (dv_sb[0]) begin
                n_f[l] = F_ZERO;
            end else if (dv_sb[1 + l]) begin
                n_f[l] = (dv_ovf[l] || dv_q[l] > F_MIN) ? F_MIN : (~dv_q[l] + 1'b1);
            end else begin
                n_f[l] = (dv_ovf[l] || dv_q[l] > F_MAX) ? F_MAX : dv_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_v;
        end
        if (en) begin
            r_f      <= n_f;
            r_fvalid <= !dv_sb[0];
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.force_x     = r_f[0];
    assign o_out.force_y     = r_f[1];
    assign o_out.force_z     = r_f[2];
    assign o_out.force_valid = r_fvalid;

endmodule

// ----- rtl/core/particle_spring_force.sv -----
`timescale 1ns / 1ps
// Top level of the 3D spring force block: register port, front, queue and back.
//
// Computes the Hooke spring force on one particle per transfer:
// d = p - o, |d| = floor(sqrt(dx^2 + dy^2 + dz^2)), and each component
// F_i = -sign(d_i) * floor(k * abs(|d| - L) * |d_i| / (|d| * 2^FRAC_BITS)),
// saturated to 32-bit signed. All values are fixed point with FRAC_BITS
// fraction bits (Q15.16 by default). An immovable particle (inverse mass 0)
// or a zero distance gives zero force with force_valid low.
// Throughput: one item per clock while the output is not held, fully
// pipelined; the bit-per-stage square root (33 stages) and the three-lane
// divider (33 stages) set the latency. An item passes the front register,
// queue, two squaring stages, root, stretch register, three multiply
// stages, divider and output register.
// The front stage and a short queue (FIFO_DEPTH entries) let the input
// keep taking transfers while the output is held, until both are full.
// Registers (APB, 32-bit data): 0x0 spring_constant k (unsigned, 31 bits,
// reset 1.0), 0x4 rest_length L (unsigned, 31 bits, reset 1.0). Write them
// only while no item is in flight.
module particle_spring_force #(
    parameter int FRAC_BITS  = 16,
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    psf_in_if.sink      i_in,
    psf_out_if.source   o_out
);
    import psf_pkg::*;

    logic [CFG_W-1:0] r_k;
    logic [CFG_W-1:0] r_l;
    t_reg_idx         reg_idx;
    logic             wr_en;

    logic   fr_v;
    t_item  fr_item;
    logic   q_rdy;
    logic   q_v;
    t_item  q_item;
    logic   bk_pop;

    // register file: word index taken from paddr[2]
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_K:   prdata = {1'b0, r_k};
            REG_L:   prdata = {1'b0, r_l};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
            r_l <= L_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_K:   r_k <= pwdata[CFG_W-1:0];
                REG_L:   r_l <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    psf_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .o_valid(fr_v),
        .o_item (fr_item),
        .i_ready(q_rdy)
    );

    psf_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_v   (fr_v),
        .o_push_rdy (q_rdy),
        .i_push_item(fr_item),
        .o_pop_v    (q_v),
        .i_pop      (bk_pop),
        .o_pop_item (q_item)
    );

    psf_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_v    (q_v),
        .o_pop  (bk_pop),
        .i_item (q_item),
        .i_k    (r_k),
        .i_l    (r_l),
        .o_out  (o_out)
    );

endmodule

// ----- tb/sv/particle_spring_force_test.sv -----
`timescale 1ns / 1ps
// Testbench for the 3D spring force block: directed and random items, scoreboard check.
module particle_spring_force_test;
    import psf_pkg::*;

    // Expected force of one transfer.
    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        fv;
    } t_force;

    // Scoreboard: computes the expected force of each input transfer and
    // checks output transfers against the oldest one in order.
    class force_board;
        logic [30:0] k_reg;
        logic [30:0] l_reg;
        t_force      pending[$];
        int          errors;

        function void reset_regs();
            k_reg = K_RESET;
            l_reg = L_RESET;
            pending.delete();
            errors = 0;
        endfunction

        // One axis: magnitude truncated, sign opposite to d, saturated.
        function logic [31:0] axis_force(logic [127:0] km, logic signed [33:0] dc,
                                         logic [127:0] den);
            logic [127:0] ad;
            logic [127:0] q;
            ad = (dc < 0) ? 128'(-dc) : 128'(dc);
            q  = (km * ad) / den;
            if (dc > 0) begin
                if (q > 128'h8000_0000) return F_MIN;
                return 32'(-q);
            end
            if (q > 128'h7FFF_FFFF) return F_MAX;
            return q[31:0];
        endfunction

        function void note_input(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz, logic signed [31:0] ox,
                                 logic signed [31:0] oy, logic signed [31:0] oz,
                                 logic [30:0] im);
            logic signed [33:0] dx, dy, dz;
            logic [127:0] s, len, c, m, km;
            t_force f;
            dx = 34'(px) - 34'(ox);
            dy = 34'(py) - 34'(oy);
            dz = 34'(pz) - 34'(oz);
            s = (128'(dx) * 128'(dx)) + (128'(dy) * 128'(dy)) + (128'(dz) * 128'(dz));
            len = 0;
            for (int b = 34; b >= 0; b--) begin
                c = len | (128'd1 << b);
                if (c * c <= s) len = c;
            end
            if (im == 0 || len == 0) begin
                f = '{F_ZERO, F_ZERO, F_ZERO, 1'b0};
            end else begin
                m  = (len >= l_reg) ? len - l_reg : l_reg - len;
                km = 128'(k_reg) * m;
                f.fx = axis_force(km, dx, len << 16);
                f.fy = axis_force(km, dy, len << 16);
                f.fz = axis_force(km, dz, len << 16);
                f.fv = 1'b1;
            end
            pending.push_back(f);
        endfunction

        function void check_result(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                                   logic fv);
            t_force e;
            if (pending.size() == 0) begin
                $error("force transfer with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (fx !== e.fx) begin
                $error("force_x exp %h got %h", e.fx, fx);
                errors++;
            end
            if (fy !== e.fy) begin
                $error("force_y exp %h got %h", e.fy, fy);
                errors++;
            end
            if (fz !== e.fz) begin
                $error("force_z exp %h got %h", e.fz, fz);
                errors++;
            end
            if (fv !== e.fv) begin
                $error("force_valid exp %b got %b", e.fv, fv);
                errors++;
            end
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 120;   // settling wait after the last expected result
    localparam int STALL_LIMIT  = 20000; // cycles with no transfer before giving up

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    psf_in_if  in_ch();
    psf_out_if out_ch();

    particle_spring_force u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    force_board board = new();
    bit         sink_hold = 1'b0;   // long receiver hold-off requested
    int         idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.anchor_x = '0;
        in_ch.anchor_y = '0;
        in_ch.anchor_z = '0;
        in_ch.inverse_mass = '0;
        out_ch.ready = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random ready, plus the long hold-off when requested.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (sink_hold) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.force_x, out_ch.force_y, out_ch.force_z,
                               out_ch.force_valid);
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [30:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) << 2;
        pwdata  <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // psel low again before a following write starts on a fresh edge
        @(posedge i_clk);
        if (idx == REG_K) board.k_reg = value;
        else board.l_reg = value;
    endtask

    // Offer one item and hold it until the transfer; valid stays high if
    // another item follows back to back.
    task automatic send_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [30:0] im, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.pos_x        <= px;
        in_ch.pos_y        <= py;
        in_ch.pos_z        <= pz;
        in_ch.anchor_x     <= ox;
        in_ch.anchor_y     <= oy;
        in_ch.anchor_z     <= oz;
        in_ch.inverse_mass <= im;
        @(posedge i_clk iff in_ch.ready);
        board.note_input(px, py, pz, ox, oy, oz, im);
    endtask

    // Drop valid on the edge of the last transfer, then wait for all results.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random coordinate: full range, or small near-origin values that keep
    // |d| modest so forces do not always saturate.
    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic logic [30:0] rnd_cfg();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(0, 32'h0004_0000));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic random_items(int count);
        logic [31:0] px, py, pz;
        logic [30:0] im;
        for (int i = 0; i < count; i++) begin
            px = rnd_coord();
            py = rnd_coord();
            pz = rnd_coord();
            im = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom());
            if ($urandom_range(0, 19) == 0)
                // zero distance: anchor on the particle
                send_item(px, py, pz, px, py, pz, im, gap_len());
            else
                send_item(px, py, pz, rnd_coord(), rnd_coord(), rnd_coord(), im,
                          gap_len());
        end
    endtask

    initial begin
        logic [31:0] one;
        one = 32'h0001_0000;
        board.reset_regs();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under reset registers (k = 1.0, L = 1.0).
        send_item(0, 0, 0, 0, 0, 0, 31'd1, 0);                     // zero distance
        send_item(one, 0, 0, 0, 0, 0, 31'd0, 0);                   // immovable
        send_item(2 * one, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 0);       // stretched, +x
        send_item(0, 0, 0, 0, 3 * one, 0, 31'd1, 0);               // stretched, -y
        send_item(0, 0, one / 2, 0, 0, 0, 31'd1, 0);               // compressed
        send_item(one, one, one, 0, 0, 0, 31'd1, 0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd1, 0);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 0);
        send_item(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 31'd1, 0);         // smallest |d|
        send_item(one, 0, 0, 0, 0, 0, 31'd1, 0);                   // at rest length
        wait_drained();

        // Extreme registers: huge k saturates, zero k and L.
        reg_write(REG_K, 31'h7FFF_FFFF);
        reg_write(REG_L, 31'd0);
        send_item(5 * one, 0, 0, 0, 0, 0, 31'd1, 0);
        send_item(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 31'd1, 0);
        send_item(0, 0, 1, 0, 0, 0, 31'd1, 0);
        send_item(32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0, 31'd1, 0);
        wait_drained();
        reg_write(REG_K, 31'd0);
        reg_write(REG_L, 31'h7FFF_FFFF);
        send_item(one, one, 0, 0, 0, 0, 31'd1, 0);
        send_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 31'd1, 0);
        wait_drained();
        reg_write(REG_K, 31'd65536);
        reg_write(REG_L, 31'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 31'd1, 0);
        send_item(3, 0, 0, 0, 0, 0, 31'd1, 0);
        wait_drained();

        // Random phases, each under fresh register values.
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_K, (ph == 0) ? 31'd65536 : rnd_cfg());
            reg_write(REG_L, (ph == 0) ? 31'd65536 : rnd_cfg());
            if (ph == 3) begin
                // Long receiver hold-off while items keep coming back to back,
                // more than the whole pipeline holds.
                sink_hold = 1'b1;
                for (int i = 0; i < 100; i++)
                    send_item(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                              rnd_coord(), rnd_coord(), 31'($urandom()), 0);
            end
            random_items(240);
            // Sender pauses until every expected result has come.
            wait_drained();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
